### rtl/core/sett_pkg.sv
// Package for the scheduled event timer table.
// Holds operation, result and state codes, the table entry layout and the
// command and status bundles shared by the controller and the datapath.
package sett_pkg;

	// Operation carried by an input item.
	typedef enum logic [1:0] {
		OP_SCHEDULE   = 2'd0,
		OP_CANCEL_ONE = 2'd1,
		OP_CANCEL_ALL = 2'd2,
		OP_ADVANCE    = 2'd3
	} op_t;

	// Kind of a result item.
	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// Status of a result item.
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} stat_code_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCHED,
		S_INIT,
		S_SWEEP,
		S_DRAIN_RD,
		S_DRAIN_OUT,
		S_FINISH
	} state_t;

	// One table entry; the repeat limit is a 17-bit two's complement value.
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] interval;
		logic [31:0] elapsed;
		logic [16:0] limit;
		logic [15:0] done;
		logic        active;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  capture;
		logic  sched;
		logic  sweep_init;
		logic  sweep_run;
		logic  sweep_finish;
		logic  out_load;
		kind_t out_kind;
		logic  out_last;
		logic  drain_next;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_done;
		logic fire_pending;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/core/sett_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sett_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sett_dp.sv
// Datapath of the scheduled event timer table: entry table, fired-id buffer,
// sweep counters, bookkeeping registers and the result register.
// Depends on sett_pkg and sett_ram.
module sett_dp import sett_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cmd_t                              cmd,
	output dp_stat_t                          stat,
	input  logic [1:0]                        op,
	input  logic [31:0]                       interval_ticks,
	input  logic [16:0]                       repeat_limit,
	input  logic [31:0]                       target_id,
	input  logic [31:0]                       delta_ticks,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic [31:0]                       event_id,
	output logic [1:0]                        status,
	output logic [$clog2(SLOTS+1)-1:0]        active_count,
	output logic                              last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Captured item.
	op_t         op_q;
	logic [31:0] interval_q;
	logic [16:0] limit_q;
	logic [31:0] target_q;
	logic [31:0] delta_q;

	// Bookkeeping.
	logic [CW-1:0] used_q;
	logic [CW-1:0] act_q;
	logic [31:0]   next_id_q;

	// Sweep state.
	logic [CW-1:0] rd_cnt_q;
	logic [CW-1:0] wr_cnt_q;
	logic [CW-1:0] fire_cnt_q;
	logic [CW-1:0] drain_q;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic          dec_q;
	stat_code_t    res_status_q;

	// Memory ports.
	logic               tbl_we;
	logic [IW-1:0]      tbl_waddr;
	logic [ENTRY_W-1:0] tbl_wdata;
	logic [ENTRY_W-1:0] tbl_rdata;
	logic               fire_we;
	logic [31:0]        fire_rdata;

	// Per-entry processing.
	entry_t      ent;
	entry_t      ent_off;
	entry_t      ent_upd;
	entry_t      ent_new;
	logic [32:0] sum33;
	logic [31:0] sat;
	logic        fire;
	logic [15:0] done_inc;
	logic        counted;
	logic        retire;
	logic        keep;
	logic        match;
	logic        full;
	logic        issue;

	sett_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (tbl_rdata)
	);

	sett_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_fire (
		.clk   (clk),
		.we    (fire_we),
		.waddr (fire_cnt_q[IW-1:0]),
		.wdata (ent.id),
		.raddr (drain_q[IW-1:0]),
		.rdata (fire_rdata)
	);

	// Timer update of the entry read in the previous cycle.
	always_comb begin
		ent      = entry_t'(tbl_rdata);
		sum33    = {1'b0, ent.elapsed} + {1'b0, delta_q};
		sat      = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
		fire     = (sat >= ent.interval);
		done_inc = ent.done + 16'd1;
		counted  = fire && !ent.limit[16] && (ent.limit != 17'd0);
		retire   = fire && ((ent.limit == 17'd0) || (counted && done_inc >= ent.limit[15:0]));
		keep     = ent.active && !retire;
		match    = (ent.id == target_q);
		ent_upd         = ent;
		ent_upd.elapsed = fire ? (sat - ent.interval) : sat;
		ent_upd.done    = counted ? done_inc : ent.done;
		ent_off         = ent;
		ent_off.active  = 1'b0;
		ent_new.id       = next_id_q;
		ent_new.interval = interval_q;
		ent_new.elapsed  = 32'd0;
		ent_new.limit    = limit_q;
		ent_new.done     = 16'd0;
		ent_new.active   = 1'b1;
		full  = (used_q == CW'(SLOTS));
		issue = cmd.sweep_run && (rd_cnt_q != used_q);
	end

	// Table write port selection.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = used_q[IW-1:0];
		tbl_wdata = ent_new;
		fire_we   = 1'b0;
		if (cmd.sched && !full) begin
			tbl_we = 1'b1;
		end else if (cmd.sweep_run && v_s1) begin
			case (op_q)
				OP_CANCEL_ONE: begin
					if (!found_q && match) begin
						tbl_we    = 1'b1;
						tbl_waddr = idx_s1;
						tbl_wdata = ent_off;
					end
				end
				OP_CANCEL_ALL: begin
					tbl_we    = 1'b1;
					tbl_waddr = idx_s1;
					tbl_wdata = ent_off;
				end
				OP_ADVANCE: begin
					tbl_we    = keep;
					tbl_waddr = wr_cnt_q[IW-1:0];
					tbl_wdata = ent_upd;
					fire_we   = ent.active && fire;
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			act_q        <= '0;
			next_id_q    <= 32'd1;
			rd_cnt_q     <= '0;
			wr_cnt_q     <= '0;
			fire_cnt_q   <= '0;
			drain_q      <= '0;
			v_s1         <= 1'b0;
			found_q      <= 1'b0;
			dec_q        <= 1'b0;
			res_status_q <= STAT_OK;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.sched && !full) begin
				used_q    <= used_q + CW'(1);
				act_q     <= act_q + CW'(1);
				next_id_q <= next_id_q + 32'd1;
			end
			if (cmd.sweep_init) begin
				rd_cnt_q   <= '0;
				wr_cnt_q   <= '0;
				fire_cnt_q <= '0;
				drain_q    <= '0;
				v_s1       <= 1'b0;
				found_q    <= 1'b0;
				dec_q      <= 1'b0;
			end
			if (cmd.sweep_run) begin
				v_s1 <= issue;
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				if (v_s1 && op_q == OP_CANCEL_ONE && !found_q && match) begin
					found_q <= 1'b1;
					dec_q   <= ent.active;
				end
				if (v_s1 && op_q == OP_ADVANCE && keep) begin
					wr_cnt_q <= wr_cnt_q + CW'(1);
				end
				if (fire_we) begin
					fire_cnt_q <= fire_cnt_q + CW'(1);
				end
			end
			if (cmd.sweep_finish) begin
				case (op_q)
					OP_CANCEL_ONE: begin
						act_q        <= act_q - CW'(dec_q);
						res_status_q <= found_q ? STAT_OK : STAT_NOT_FOUND;
					end
					OP_CANCEL_ALL: begin
						act_q        <= '0;
						res_status_q <= STAT_OK;
					end
					OP_ADVANCE: begin
						used_q       <= wr_cnt_q;
						act_q        <= wr_cnt_q;
						res_status_q <= STAT_OK;
					end
					default: res_status_q <= STAT_OK;
				endcase
			end
			if (cmd.drain_next) begin
				drain_q <= drain_q + CW'(1);
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers: captured item, stage index and result fields.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op_t'(op);
			interval_q <= interval_ticks;
			limit_q    <= repeat_limit;
			target_q   <= target_id;
			delta_q    <= delta_ticks;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[IW-1:0];
		end
		if (cmd.out_load) begin
			kind <= cmd.out_kind;
			last <= cmd.out_last;
			case (cmd.out_kind)
				KIND_ACK: begin
					event_id     <= full ? 32'd0 : next_id_q;
					status       <= full ? STAT_FULL : STAT_OK;
					active_count <= full ? act_q : act_q + CW'(1);
				end
				KIND_FIRED: begin
					event_id     <= fire_rdata;
					status       <= STAT_OK;
					active_count <= act_q;
				end
				default: begin
					event_id     <= 32'd0;
					status       <= res_status_q;
					active_count <= act_q;
				end
			endcase
		end
	end

	// Status back to the controller.
	assign stat.sweep_done   = (rd_cnt_q == used_q) && !v_s1;
	assign stat.fire_pending = (drain_q != fire_cnt_q);
	assign stat.out_free     = !out_valid || out_ready;

endmodule

### rtl/core/sett_ctrl.sv
// Controller of the scheduled event timer table: sequences schedule,
// table sweeps, fired-id drain and the final result of each item.
// Depends on sett_pkg.
module sett_ctrl import sett_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  dp_stat_t   stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.out_kind = KIND_DONE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (op_t'(op) == OP_SCHEDULE) ? S_SCHED : S_INIT;
				end
			end
			S_SCHED: begin
				if (stat.out_free) begin
					cmd.sched    = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_ACK;
					cmd.out_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_INIT: begin
				cmd.sweep_init = 1'b1;
				state_d = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_done) begin
					cmd.sweep_finish = 1'b1;
					state_d = S_DRAIN_RD;
				end
			end
			S_DRAIN_RD: begin
				state_d = stat.fire_pending ? S_DRAIN_OUT : S_FINISH;
			end
			S_DRAIN_OUT: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_kind   = KIND_FIRED;
					cmd.drain_next = 1'b1;
					state_d = S_DRAIN_RD;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_DONE;
					cmd.out_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### rtl/core/scheduled_event_timer_table.sv
// Scheduled event timer table: up to SLOTS timer entries in creation order.
// Input channel (in_valid/in_ready) takes one item: op selects schedule,
// cancel one, cancel all or advance time; the other fields are its operands.
// Output channel (out_valid/out_ready) gives the result items of that item:
// one acknowledgement for a schedule, one finished result for a cancel, and
// for an advance one fired result per firing entry in table order followed
// by one finished result. The final result of an item carries last = 1.
// Items are handled one at a time; in_ready is high only between items.
// Sequencing: a schedule is captured in S_IDLE and acknowledged from S_SCHED
// once the result register is free. A cancel or an advance sweeps the occupied
// entries through the table RAM read port, one entry a cycle; its final
// result is loaded from S_FINISH after S_INIT, S_SWEEP and one pass through
// S_DRAIN_RD and S_DRAIN_OUT per fired result.
// A stalled receiver holds the result register and the sequencer waits; the
// next item is still accepted while the final result of the previous one
// waits to be taken. Reset empties the table and sets the next id to one;
// the table RAM needs no clearing since only occupied entries are read.
// Depends on sett_pkg, sett_ctrl, sett_dp and sett_ram.
module scheduled_event_timer_table import sett_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [31:0]                interval_ticks,
	input  logic signed [16:0]         repeat_limit,
	input  logic [31:0]                target_id,
	input  logic [31:0]                delta_ticks,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 kind,
	output logic [31:0]                event_id,
	output logic [1:0]                 status,
	output logic [$clog2(SLOTS+1)-1:0] active_count,
	output logic                       last
);

	cmd_t     cmd;
	dp_stat_t dp_stat;

	sett_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.stat     (dp_stat),
		.cmd      (cmd)
	);

	sett_dp #(.SLOTS(SLOTS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (dp_stat),
		.op             (op),
		.interval_ticks (interval_ticks),
		.repeat_limit   (repeat_limit),
		.target_id      (target_id),
		.delta_ticks    (delta_ticks),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.event_id       (event_id),
		.status         (status),
		.active_count   (active_count),
		.last           (last)
	);

	// One item at a time: after an item is taken the input stays closed.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in progress");

	// A schedule acknowledgement is always the only result of its item.
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ACK |-> last)
		else $error("acknowledgement not marked last");

	// A fired result is always followed by the finished result.
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FIRED |-> !last)
		else $error("fired result marked last");

	// The active count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_count <= ($clog2(SLOTS+1))'(SLOTS))
		else $error("active count out of range");

endmodule
